// ===== src/otct_pkg.sv =====
// Shared types and codes for the owned countdown timer table.
// Used by otct_cell and owned_countdown_timer_table; no dependencies.
package otct_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int USER_DEFAULT  = 15;
  localparam logic [7:0] DEFER_RESET = 8'd60;
  localparam logic signed [15:0] COUNT_FLOOR = -16'sd32768;

  // request codes
  localparam logic [2:0] REQ_START      = 3'd0;
  localparam logic [2:0] REQ_CANCEL_ID  = 3'd1;
  localparam logic [2:0] REQ_CANCEL_OWN = 3'd2;
  localparam logic [2:0] REQ_CHECK      = 3'd3;
  localparam logic [2:0] REQ_TICK       = 3'd4;

  // result codes
  localparam logic [2:0] RES_DONE      = 3'd0;
  localparam logic [2:0] RES_FULL      = 3'd1;
  localparam logic [2:0] RES_FOUND     = 3'd2;
  localparam logic [2:0] RES_NOT_FOUND = 3'd3;
  localparam logic [2:0] RES_FIRED     = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [4:0]         owner;
    logic [15:0]        id;
    logic signed [15:0] count;
    logic [31:0]        val_a;
    logic [31:0]        val_b;
    logic [7:0]         kind_a;
    logic [7:0]         kind_b;
  } entry_t;

  typedef struct packed {
    logic rotate;  // every cell takes its right neighbor
    logic insert;  // cells up to and including the first hole take their left neighbor
  } cell_ctl_t;

endpackage

// ===== src/otct_cell.sv =====
// One timer cell of the age-ordered chain.
// Depends on otct_pkg.
module otct_cell
  import otct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    from_prev,
  input  entry_t    from_next,
  input  logic      hole_before,
  output logic      hole_after,
  output entry_t    entry
);

  // pass the hole mark on to the older neighbor
  assign hole_after = hole_before | ~entry.valid;

  // advance on a walk, shift down on an insert, else hold
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctl.rotate) begin
      entry <= from_next;
    end else if (ctl.insert && !hole_before) begin
      entry <= from_prev;
    end
  end

endmodule

// ===== src/owned_countdown_timer_table.sv =====
// Top level of the owned countdown timer table: control, head processing
// and output register around a chain of otct_cell. Depends on otct_pkg.
//
// Usage:
//   Requests enter on in_valid/in_ready, one beat per request. Results leave
//   on out_valid/out_ready, one beat per result; the final beat of a request
//   carries last = 1. defer_ticks is written on cfg_valid/cfg_ready (always
//   ready), by the user only while the block is idle; it is not enforced.
//   Timers sit in a chain of TABLE_DEPTH cells ordered newest first. A start
//   shifts the chain by one unless the table is full. Cancel, check and tick
//   walk the chain once, one cell per cycle while the output register is
//   free, as it rotates through the head logic; each fired timer of a tick
//   leaves as a beat during the walk, newest first.
//   A request is taken only when the previous one has given its last beat.
//   When the receiver stalls, the walk pauses with the pending beat held in
//   the output register. Reset empties the table and sets defer_ticks to 60.
module owned_countdown_timer_table
  import otct_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int USER_LINES  = USER_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         defer_ticks,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [4:0]         owner,
  input  logic [15:0]        timer_id,
  input  logic [14:0]        start_count,
  input  logic signed [31:0] val_a,
  input  logic signed [31:0] val_b,
  input  logic [7:0]         kind_a,
  input  logic [7:0]         kind_b,
  input  logic [1:0]         shared_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         result_kind,
  output logic [15:0]        fired_id,
  output logic [4:0]         fired_owner,
  output logic signed [31:0] out_val_a,
  output logic signed [31:0] out_val_b,
  output logic [7:0]         out_kind_a,
  output logic [7:0]         out_kind_b,
  output logic signed [15:0] remaining,
  output logic               last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {IDLE, START, WALK, FINISH} state_t;

  state_t            state;
  logic [CW-1:0]     step;
  logic [CW-1:0]     total;
  logic [7:0]        defer;
  logic [2:0]        rq_type;
  logic [4:0]        rq_owner;
  logic [15:0]       rq_id;
  logic [1:0]        rq_ready;
  entry_t            rq_entry;
  logic              found;
  logic signed [15:0] found_count;

  entry_t            cells [TABLE_DEPTH];
  logic              holes [TABLE_DEPTH+1];
  entry_t            head_next;
  cell_ctl_t         ctl;

  logic              out_free;
  logic              head_match;
  logic              head_drop;
  logic              head_fire;
  logic              shared_line;
  logic [4:0]        shared_idx;
  logic              line_ready;
  logic signed [15:0] dec_count;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign out_free  = ~out_valid | out_ready;

  // hold the defer amount
  always_ff @(posedge clk) begin
    if (rst) begin
      defer <= DEFER_RESET;
    end else if (cfg_valid) begin
      defer <= defer_ticks;
    end
  end

  // judge the entry at the head of the chain
  always_comb begin
    head_next   = cells[0];
    shared_line = cells[0].owner >= 5'(USER_LINES);
    shared_idx  = cells[0].owner - 5'(USER_LINES);
    line_ready  = (shared_idx < 5'd2) && rq_ready[shared_idx[0]];
    head_match  = cells[0].valid && (cells[0].id == rq_id) &&
                  (shared_line || cells[0].owner == rq_owner);
    dec_count   = (cells[0].count == COUNT_FLOOR) ? cells[0].count
                                                  : cells[0].count - 16'sd1;
    head_drop   = 1'b0;
    head_fire   = 1'b0;
    case (rq_type)
      REQ_CANCEL_ID: head_drop = head_match;
      REQ_CANCEL_OWN: head_drop = cells[0].valid && cells[0].owner == rq_owner;
      REQ_TICK: begin
        if (cells[0].valid) begin
          head_next.count = dec_count;
          if (dec_count <= 16'sd0) begin
            if (shared_line && !line_ready) begin
              head_next.count = dec_count + $signed({8'd0, defer});
            end else begin
              head_fire = 1'b1;
              head_drop = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (head_drop) head_next.valid = 1'b0;
  end

  // steer the chain
  always_comb begin
    ctl.rotate = (state == WALK) && out_free;
    ctl.insert = (state == START) && out_free && (total < CW'(TABLE_DEPTH));
  end

  assign holes[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_t from_prev;
      entry_t from_next;
      if (g == 0) begin : g_first
        assign from_prev = rq_entry;
      end else begin : g_mid
        assign from_prev = cells[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_tail
        assign from_next = head_next;
      end else begin : g_body
        assign from_next = cells[g+1];
      end
      otct_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .from_prev  (from_prev),
        .from_next  (from_next),
        .hole_before(holes[g]),
        .hole_after (holes[g+1]),
        .entry      (cells[g])
      );
    end
  endgenerate

  // sequence requests, keep the count and drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (out_ready) out_valid <= 1'b0;
          if (in_valid) begin
            rq_type  <= req_type;
            rq_owner <= owner;
            rq_id    <= timer_id;
            rq_ready <= shared_ready;
            rq_entry <= '{valid: 1'b1, owner: owner, id: timer_id,
                          count: $signed({1'b0, start_count}), val_a: val_a,
                          val_b: val_b, kind_a: kind_a, kind_b: kind_b};
            found    <= 1'b0;
            step     <= '0;
            if (req_type == REQ_START) begin
              state <= START;
            end else if (req_type == REQ_CANCEL_ID || req_type == REQ_CANCEL_OWN ||
                         req_type == REQ_CHECK || req_type == REQ_TICK) begin
              state <= WALK;
            end else begin
              state <= FINISH;
            end
          end
        end
        START: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_kind <= (total < CW'(TABLE_DEPTH)) ? RES_DONE : RES_FULL;
            fired_id    <= '0;
            fired_owner <= '0;
            out_val_a   <= '0;
            out_val_b   <= '0;
            out_kind_a  <= '0;
            out_kind_b  <= '0;
            remaining   <= '0;
            last        <= 1'b1;
            if (total < CW'(TABLE_DEPTH)) total <= total + 1'b1;
            state <= IDLE;
          end
        end
        WALK: begin
          if (out_free) begin
            if (head_drop) total <= total - 1'b1;
            if (rq_type == REQ_CHECK && head_match && !found) begin
              found       <= 1'b1;
              found_count <= cells[0].count;
            end
            if (head_fire) begin
              out_valid   <= 1'b1;
              result_kind <= RES_FIRED;
              fired_id    <= cells[0].id;
              fired_owner <= cells[0].owner;
              out_val_a   <= cells[0].val_a;
              out_val_b   <= cells[0].val_b;
              out_kind_a  <= cells[0].kind_a;
              out_kind_b  <= cells[0].kind_b;
              remaining   <= '0;
              last        <= 1'b0;
            end else if (out_ready) begin
              out_valid <= 1'b0;
            end
            step <= step + 1'b1;
            if (step == CW'(TABLE_DEPTH - 1)) state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            fired_id    <= '0;
            fired_owner <= '0;
            out_val_a   <= '0;
            out_val_b   <= '0;
            out_kind_a  <= '0;
            out_kind_b  <= '0;
            last        <= 1'b1;
            remaining   <= (rq_type == REQ_CHECK && found) ? found_count : '0;
            result_kind <= (rq_type != REQ_CHECK) ? RES_DONE :
                           found ? RES_FOUND : RES_NOT_FOUND;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // count of live timers never exceeds the chain length
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(TABLE_DEPTH))
    else $error("timer count exceeds table depth");

  // a fired beat is never the last of its request
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RES_FIRED |-> !last)
    else $error("fired beat marked last");

  // a taken request closes the input until it completes
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // the chain only rotates during a walk, never together with an insert
  a_rotate_walk: assert property (@(posedge clk) disable iff (rst)
    ctl.rotate |-> state == WALK && !ctl.insert)
    else $error("chain rotated outside a walk");

endmodule
